// File: rtl/tesp_pkg.sv
// ----------------------------------------------------------------------------
// Terminal escape sequence parser package
// Shared constants, codes and types of the escape sequence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tesp_pkg;

    localparam int ARG_WIDTH_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRKT = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [1:0] {
        ACT_PRINT = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_HOME  = 2'd2,
        ACT_MOVE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } t_phase;

    localparam logic [1:0] CNT_ZERO = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_SAT  = 2'd3;

    typedef struct packed {
        logic       is_print;
        logic [7:0] code;
        logic [1:0] arg_count;
    } t_cmd_ctrl;

endpackage

`default_nettype wire

// File: rtl/tesp_ifs.sv
// ----------------------------------------------------------------------------
// Terminal escape sequence parser channels
// Valid/ready channels for incoming bytes and outgoing terminal commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface tesp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tesp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] row_param;
    logic [7:0] col_param;

    modport source (output valid, output action, output char_code, output row_param,
                    output col_param, input ready);
    modport sink   (input valid, input action, input char_code, input row_param,
                    input col_param, output ready);
endinterface

`default_nettype wire

// File: rtl/tesp_front.sv
// ----------------------------------------------------------------------------
// Escape sequence parser front end
// Tracks the sequence phase, gathers parameters and hands completed
// print and command items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_front
    import tesp_pkg::*;
#(
    parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_last,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output t_cmd_ctrl                 o_ctrl,
    output logic [ARG_WIDTH-1:0]      o_arg0,
    output logic [ARG_WIDTH-1:0]      o_arg1
);

    localparam int                   PROD_W  = ARG_WIDTH + 4;
    localparam logic [PROD_W-1:0]    ARG_MAX = PROD_W'({ARG_WIDTH{1'b1}});

    t_phase                 r_phase, n_phase;
    logic [ARG_WIDTH-1:0]   r_arg0, n_arg0;
    logic [ARG_WIDTH-1:0]   r_arg1, n_arg1;
    logic [ARG_WIDTH-1:0]   r_acc, n_acc;
    logic [1:0]             r_cnt, n_cnt;
    logic                   r_seen, n_seen;

    logic                   accept;
    logic                   is_digit;
    logic [PROD_W-1:0]      acc_prod;
    logic [ARG_WIDTH-1:0]   acc_digit;
    logic [ARG_WIDTH-1:0]   fin_arg0;
    logic [ARG_WIDTH-1:0]   fin_arg1;
    logic [1:0]             fin_cnt;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign is_digit = (i_data_byte >= CH_0) && (i_data_byte <= CH_9);

    assign acc_prod = (PROD_W'(r_acc) << 3) + (PROD_W'(r_acc) << 1)
                    + PROD_W'(i_data_byte - CH_0);
    assign acc_digit = (acc_prod > ARG_MAX) ? ARG_MAX[ARG_WIDTH-1:0]
                                            : acc_prod[ARG_WIDTH-1:0];

    assign fin_arg0 = (r_cnt == CNT_ZERO) ? r_acc : r_arg0;
    assign fin_arg1 = (r_cnt == CNT_ONE)  ? r_acc : r_arg1;
    assign fin_cnt  = (r_cnt == CNT_SAT)  ? CNT_SAT : r_cnt + 2'd1;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_data_byte == CH_ESC) begin
                        n_phase = PH_ESC;
                    end
                end
                PH_ESC: begin
                    n_phase = (i_data_byte == CH_LBRKT) ? PH_PARAM : PH_IDLE;
                end
                PH_PARAM: begin
                    if (!is_digit && i_data_byte != CH_SEMI) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
            if (i_last) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        n_arg0          = r_arg0;
        n_arg1          = r_arg1;
        n_acc           = r_acc;
        n_cnt           = r_cnt;
        n_seen          = r_seen;
        o_push          = 1'b0;
        o_ctrl.is_print = 1'b0;
        o_ctrl.code     = i_data_byte;
        o_ctrl.arg_count = CNT_ZERO;
        o_arg0          = '0;
        o_arg1          = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_data_byte != CH_ESC) begin
                    o_push          = accept;
                    o_ctrl.is_print = 1'b1;
                end else begin
                    n_arg0 = '0;
                    n_arg1 = '0;
                    n_acc  = '0;
                    n_cnt  = CNT_ZERO;
                    n_seen = 1'b0;
                end
            end
            PH_ESC: begin
                n_arg0 = '0;
                n_arg1 = '0;
                n_acc  = '0;
                n_cnt  = CNT_ZERO;
                n_seen = 1'b0;
                if (i_data_byte != CH_LBRKT) begin
                    o_push = accept;
                end
            end
            PH_PARAM: begin
                if (is_digit) begin
                    n_acc  = acc_digit;
                    n_seen = 1'b1;
                end else if (i_data_byte == CH_SEMI) begin
                    n_arg0 = fin_arg0;
                    n_arg1 = fin_arg1;
                    n_cnt  = fin_cnt;
                    n_acc  = '0;
                    n_seen = 1'b1;
                end else begin
                    o_push = accept;
                    if (r_seen) begin
                        o_ctrl.arg_count = fin_cnt;
                        o_arg0           = fin_arg0;
                        o_arg1           = fin_arg1;
                    end else begin
                        o_ctrl.arg_count = r_cnt;
                        o_arg0           = r_arg0;
                        o_arg1           = r_arg1;
                    end
                    n_arg0 = '0;
                    n_arg1 = '0;
                    n_acc  = '0;
                    n_cnt  = CNT_ZERO;
                    n_seen = 1'b0;
                end
            end
            default: begin
                n_arg0 = '0;
                n_arg1 = '0;
                n_acc  = '0;
                n_cnt  = CNT_ZERO;
                n_seen = 1'b0;
            end
        endcase
        if (i_last) begin
            n_arg0 = '0;
            n_arg1 = '0;
            n_acc  = '0;
            n_cnt  = CNT_ZERO;
            n_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_arg0  <= '0;
            r_arg1  <= '0;
            r_acc   <= '0;
            r_cnt   <= CNT_ZERO;
            r_seen  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                r_arg0 <= n_arg0;
                r_arg1 <= n_arg1;
                r_acc  <= n_acc;
                r_cnt  <= n_cnt;
                r_seen <= n_seen;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/tesp_queue.sv
// ----------------------------------------------------------------------------
// Escape sequence parser command queue
// Small first-in first-out queue between the parser and the command stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_queue
    import tesp_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tesp_back.sv
// ----------------------------------------------------------------------------
// Escape sequence parser command stage
// Decodes queued items into terminal commands and holds them in an
// output register until the downstream side takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module tesp_back
    import tesp_pkg::*;
#(
    parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    output logic                      o_pop,
    input  wire t_cmd_ctrl            i_ctrl,
    input  wire logic [ARG_WIDTH-1:0] i_arg0,
    input  wire logic [ARG_WIDTH-1:0] i_arg1,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_action,
    output logic [7:0]                o_char_code,
    output logic [7:0]                o_row_param,
    output logic [7:0]                o_col_param
);

    localparam int EXT_W = ARG_WIDTH + 8;

    logic               r_valid;
    t_action            r_action, n_action;
    logic [7:0]         r_char, n_char;
    logic [7:0]         r_row, n_row;
    logic [7:0]         r_col, n_col;
    logic               has_result;
    logic [EXT_W-1:0]   arg0_ext;
    logic [EXT_W-1:0]   arg1_ext;

    assign arg0_ext = EXT_W'(i_arg0);
    assign arg1_ext = EXT_W'(i_arg1);
    assign o_pop    = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        has_result = 1'b0;
        n_action   = ACT_PRINT;
        n_char     = 8'd0;
        n_row      = 8'd0;
        n_col      = 8'd0;
        if (i_ctrl.is_print) begin
            has_result = 1'b1;
            n_char     = i_ctrl.code;
        end else if (i_ctrl.code == CH_J) begin
            if (i_ctrl.arg_count != CNT_ZERO && i_arg0 == ARG_WIDTH'(2)) begin
                has_result = 1'b1;
                n_action   = ACT_CLEAR;
            end
        end else if (i_ctrl.code == CH_H) begin
            if (i_ctrl.arg_count == CNT_ZERO) begin
                has_result = 1'b1;
                n_action   = ACT_HOME;
            end else if (i_ctrl.arg_count == CNT_TWO) begin
                has_result = 1'b1;
                n_action   = ACT_MOVE;
                n_row      = arg0_ext[7:0];
                n_col      = arg1_ext[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= has_result;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= n_action;
            r_char   <= n_char;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

    assign o_valid     = r_valid;
    assign o_action    = r_action;
    assign o_char_code = r_char;
    assign o_row_param = r_row;
    assign o_col_param = r_col;

endmodule

`default_nettype wire

// File: rtl/terminal_escape_sequence_parser_core.sv
// ----------------------------------------------------------------------------
// Terminal escape sequence parser
// Turns a byte stream into print, clear-screen, cursor-home and
// cursor-move commands.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the queue is not full,
// since each accepted byte updates the parser state registers directly.
// A transfer on the byte channel reaches the command channel through the
// parser, the queue (two entries by default) and the output register, in
// that order. Bytes that open or continue an escape sequence, and commands
// that are not recognised, give no transfer on the command channel. The
// byte channel stalls only when the queue is full, which happens when the
// command channel is held off.
`default_nettype none

module terminal_escape_sequence_parser_core
    import tesp_pkg::*;
#(
    parameter int ARG_WIDTH   = ARG_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tesp_byte_if.sink  i_byte,
    tesp_cmd_if.source o_cmd
);

    localparam int CTRL_W = $bits(t_cmd_ctrl);
    localparam int DATA_W = CTRL_W + 2 * ARG_WIDTH;

    logic                 q_full;
    logic                 push;
    t_cmd_ctrl            push_ctrl;
    logic [ARG_WIDTH-1:0] push_arg0;
    logic [ARG_WIDTH-1:0] push_arg1;
    logic                 pop;
    logic                 q_valid;
    logic [DATA_W-1:0]    q_data;
    t_cmd_ctrl            pop_ctrl;

    tesp_front #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_byte.valid),
        .o_ready     (i_byte.ready),
        .i_data_byte (i_byte.data_byte),
        .i_last      (i_byte.last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_ctrl      (push_ctrl),
        .o_arg0      (push_arg0),
        .o_arg1      (push_arg1)
    );

    tesp_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ctrl, push_arg0, push_arg1}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign pop_ctrl = t_cmd_ctrl'(q_data[DATA_W-1 -: CTRL_W]);

    tesp_back #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_pop       (pop),
        .i_ctrl      (pop_ctrl),
        .i_arg0      (q_data[2*ARG_WIDTH-1 -: ARG_WIDTH]),
        .i_arg1      (q_data[ARG_WIDTH-1:0]),
        .o_valid     (o_cmd.valid),
        .i_ready     (o_cmd.ready),
        .o_action    (o_cmd.action),
        .o_char_code (o_cmd.char_code),
        .o_row_param (o_cmd.row_param),
        .o_col_param (o_cmd.col_param)
    );

endmodule

`default_nettype wire
